[rtl/bei_pkg.sv]
// shared types, constants and codes for the button and encoder input controller
package bei_pkg;

  localparam int BTN_W           = 16;
  localparam int TICK_W          = 15;
  localparam int RES_W           = 8;
  localparam int STEP_W          = 8;
  localparam int HOLD_W          = 16;
  localparam int CMD_W           = 2;
  localparam int PH_W            = 2;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 16;
  localparam int DEF_BUTTON_BITS = 16;
  localparam int DIV_STEPS       = STEP_W;

  localparam logic [TICK_W-1:0] LONG_RST  = 15'd1000;
  localparam logic [TICK_W-1:0] SHORT_RST = 15'd20;
  localparam logic [TICK_W-1:0] AUTO_RST  = 15'd200;
  localparam logic [BTN_W-1:0]  MASK_RST  = 16'd0;
  localparam logic [RES_W-1:0]  RES_RST   = 8'd4;
  localparam logic [HOLD_W-1:0] HOLD_MAX  = 16'h7FFF;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK     = 2'd0,
    CMD_READ_ENC = 2'd1,
    CMD_READ_BTN = 2'd2
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LONG  = 3'd0,
    CFG_SHORT = 3'd1,
    CFG_AUTO  = 3'd2,
    CFG_MASK  = 3'd3,
    CFG_RES   = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic load;
    logic div_step;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic needs_div;
  } ctrl_status_t;

endpackage

[rtl/bei_if.sv]
// item channel interfaces for the input and result sides
interface bei_in_if import bei_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] cmd;
  logic [BTN_W-1:0] buttons;
  logic [PH_W-1:0]  enc_phases;

  modport source (output valid, output cmd, output buttons, output enc_phases, input ready);
  modport sink   (input valid, input cmd, input buttons, input enc_phases, output ready);
endinterface

interface bei_out_if import bei_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [STEP_W-1:0] encoder_steps;
  logic [BTN_W-1:0]         button_code;
  logic                     held_long;

  modport source (output valid, output encoder_steps, output button_code, output held_long,
                  input ready);
  modport sink   (input valid, input encoder_steps, input button_code, input held_long,
                  output ready);
endinterface

[rtl/bei_ctrl.sv]
// controller state machine: item sequencing, divide iterations and result register
module bei_ctrl import bei_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  input  ctrl_status_t status_i,
  output ctrl_cmd_t    ctrl_o
);

  localparam int CntW = $clog2(DIV_STEPS);
  localparam logic [CntW-1:0] CntLast = CntW'(DIV_STEPS - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_COMMIT
  } state_e;

  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    ctrl_o      = '0;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          ctrl_o.load = 1'b1;
          cnt_d       = '0;
          state_d     = status_i.needs_div ? ST_DIV : ST_COMMIT;
        end
      end
      ST_DIV: begin
        ctrl_o.div_step = 1'b1;
        if (cnt_q == CntLast) begin
          state_d = ST_COMMIT;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_COMMIT: begin
        if (!out_valid_q || out_ready_i) begin
          ctrl_o.commit = 1'b1;
          out_valid_d   = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

[rtl/bei_dp.sv]
// datapath: settings, hold counter, quadrature counter, serial divider and result payload
module bei_dp import bei_pkg::*; #(
  parameter int BUTTON_BITS = DEF_BUTTON_BITS
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]    cfg_data_i,
  input  logic [CMD_W-1:0]         cmd_i,
  input  logic [BTN_W-1:0]         buttons_i,
  input  logic [PH_W-1:0]          phases_i,
  input  ctrl_cmd_t                ctrl_i,
  output ctrl_status_t             status_o,
  output logic signed [STEP_W-1:0] encoder_steps_o,
  output logic [BTN_W-1:0]         button_code_o,
  output logic                     held_long_o
);

  localparam int UsedBits = (BUTTON_BITS < BTN_W) ? BUTTON_BITS : BTN_W;
  localparam logic [BTN_W-1:0] BtnMask = BTN_W'(((BTN_W + 1)'(1)) << UsedBits) - 1'b1;

  // settings
  logic [TICK_W-1:0] long_q, short_q, auto_q;
  logic [BTN_W-1:0]  mask_q;
  logic [RES_W-1:0]  res_q;

  // block state
  logic signed [HOLD_W-1:0] hold_q, hold_d;
  logic [BTN_W-1:0]         prev_btn_q, prev_btn_d;
  logic [PH_W-1:0]          prev_ph_q, prev_ph_d;
  logic [STEP_W-1:0]        step_q, step_d;
  logic [BTN_W-1:0]         latched_q, latched_d;
  logic                     long_flag_q, long_flag_d;

  // item and divider registers
  logic [CMD_W-1:0]  cmd_q;
  logic [BTN_W-1:0]  btn_q;
  logic [PH_W-1:0]   ph_q;
  logic [STEP_W-1:0] rem_q, dq_q, dvs_q;

  // result payload
  logic [STEP_W-1:0] res_steps_q, res_steps_d;
  logic [BTN_W-1:0]  res_btn_q, res_btn_d;
  logic              res_long_q, res_long_d;

  logic [STEP_W-1:0] step_mag, res_mag;
  logic [STEP_W:0]   trial, diff;
  logic              fit;
  logic              q_neg, clamp;
  logic [STEP_W-1:0] q_out, r_out;

  logic signed [HOLD_W-1:0] hold_inc;
  logic                     can_inc, hit_long;
  logic signed [HOLD_W:0]   hold_x, thresh;
  logic                     rel_ok;

  assign status_o.needs_div = (cmd_i == CMD_READ_ENC) && (res_q != '0);

  assign step_mag = step_q[STEP_W-1] ? (~step_q + 1'b1) : step_q;
  assign res_mag  = res_q[RES_W-1] ? (~res_q + 1'b1) : res_q;

  // one quotient bit a step
  assign trial = {rem_q, dq_q[STEP_W-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign fit   = !diff[STEP_W];

  assign q_neg = step_q[STEP_W-1] ^ res_q[RES_W-1];
  assign clamp = !q_neg && (dq_q == {1'b1, {(STEP_W-1){1'b0}}});
  assign q_out = clamp ? {1'b0, {(STEP_W-1){1'b1}}} : (q_neg ? (~dq_q + 1'b1) : dq_q);
  assign r_out = clamp ? {STEP_W{1'b1}} : (step_q[STEP_W-1] ? (~rem_q + 1'b1) : rem_q);

  assign hold_inc = hold_q + HOLD_W'(1);
  assign can_inc  = (hold_q != HOLD_MAX);
  assign hit_long = (hold_inc == $signed({1'b0, long_q}));
  assign hold_x   = {hold_q[HOLD_W-1], hold_q};
  assign thresh   = $signed({2'b00, long_q}) - $signed({2'b00, auto_q});
  assign rel_ok   = (hold_x > $signed({2'b00, short_q})) && (hold_x < thresh);

  always_comb begin
    hold_d      = hold_q;
    prev_btn_d  = prev_btn_q;
    prev_ph_d   = prev_ph_q;
    step_d      = step_q;
    latched_d   = latched_q;
    long_flag_d = long_flag_q;
    res_steps_d = '0;
    res_btn_d   = '0;
    res_long_d  = 1'b0;
    unique case (cmd_q)
      CMD_TICK: begin
        if (btn_q != '0) begin
          if ((btn_q == prev_btn_q) && can_inc) begin
            hold_d = hold_inc;
            if (hit_long) begin
              latched_d   = btn_q;
              long_flag_d = 1'b1;
              if ((btn_q & mask_q) != '0) begin
                hold_d = hold_inc - $signed({1'b0, auto_q});
              end
            end
          end
        end else begin
          if (rel_ok) begin
            latched_d = prev_btn_q;
          end
          hold_d = '0;
        end
        prev_btn_d = btn_q;
        if (res_q != '0) begin
          case ({prev_ph_q, ph_q})
            4'b0001, 4'b0111, 4'b1110, 4'b1000: step_d = step_q + 1'b1;
            4'b0010, 4'b1011, 4'b1101, 4'b0100: step_d = step_q - 1'b1;
            default: step_d = step_q;
          endcase
          prev_ph_d = ph_q;
        end
      end
      CMD_READ_ENC: begin
        if (res_q == '0) begin
          res_steps_d = step_q;
          step_d      = '0;
        end else begin
          res_steps_d = q_out;
          step_d      = r_out;
        end
      end
      CMD_READ_BTN: begin
        res_btn_d   = latched_q;
        res_long_d  = long_flag_q;
        latched_d   = '0;
        long_flag_d = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_q      <= LONG_RST;
      short_q     <= SHORT_RST;
      auto_q      <= AUTO_RST;
      mask_q      <= MASK_RST;
      res_q       <= RES_RST;
      hold_q      <= '0;
      prev_btn_q  <= '0;
      prev_ph_q   <= '0;
      step_q      <= '0;
      latched_q   <= '0;
      long_flag_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_LONG:  long_q  <= cfg_data_i[TICK_W-1:0];
          CFG_SHORT: short_q <= cfg_data_i[TICK_W-1:0];
          CFG_AUTO:  auto_q  <= cfg_data_i[TICK_W-1:0];
          CFG_MASK:  mask_q  <= cfg_data_i[BTN_W-1:0];
          CFG_RES:   res_q   <= cfg_data_i[RES_W-1:0];
          default: begin
          end
        endcase
      end
      if (ctrl_i.commit) begin
        hold_q      <= hold_d;
        prev_btn_q  <= prev_btn_d;
        prev_ph_q   <= prev_ph_d;
        step_q      <= step_d;
        latched_q   <= latched_d;
        long_flag_q <= long_flag_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      cmd_q <= cmd_i;
      btn_q <= buttons_i & BtnMask;
      ph_q  <= phases_i;
      rem_q <= '0;
      dq_q  <= step_mag;
      dvs_q <= res_mag;
    end else if (ctrl_i.div_step) begin
      rem_q <= fit ? diff[STEP_W-1:0] : trial[STEP_W-1:0];
      dq_q  <= {dq_q[STEP_W-2:0], fit};
    end
    if (ctrl_i.commit) begin
      res_steps_q <= res_steps_d;
      res_btn_q   <= res_btn_d;
      res_long_q  <= res_long_d;
    end
  end

  assign encoder_steps_o = $signed(res_steps_q);
  assign button_code_o   = res_btn_q;
  assign held_long_o     = res_long_q;

endmodule

[rtl/button_encoder_input_controller_core.sv]
// tick and button reads go from idle to commit, which writes the result register
// an encoder read with nonzero resolution runs the bit-serial divider before commit
// no new item is taken until commit; commit waits while the last result is untaken
// the result register lets the next item run while a result waits to be taken
// reset: settings return to their defaults, hold, phase, step and latch state clear
module button_encoder_input_controller_core import bei_pkg::*; #(
  parameter int BUTTON_BITS = DEF_BUTTON_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  bei_in_if.sink                in_i,
  bei_out_if.source             out_o
);

  ctrl_cmd_t    ctrl;
  ctrl_status_t status;

  bei_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .ctrl_o      (ctrl)
  );

  bei_dp #(
    .BUTTON_BITS (BUTTON_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .cmd_i           (in_i.cmd),
    .buttons_i       (in_i.buttons),
    .phases_i        (in_i.enc_phases),
    .ctrl_i          (ctrl),
    .status_o        (status),
    .encoder_steps_o (out_o.encoder_steps),
    .button_code_o   (out_o.button_code),
    .held_long_o     (out_o.held_long)
  );

`ifndef SYNTHESIS
  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> !in_i.ready)
    else $error("input still ready after an item was taken");

  a_result_after_work : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(!in_i.ready))
    else $error("result appeared without an item in work");

  a_one_command : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({ctrl.load, ctrl.div_step, ctrl.commit}))
    else $error("controller issued more than one command");
`endif

endmodule
